// File: rtl/core/page_framebuffer_pixel_line_draw_assert.svh
// Assertion macros shared by the line draw RTL.
// Depends on nothing; each user passes its own clock and reset.
`ifndef PAGE_FRAMEBUFFER_PIXEL_LINE_DRAW_ASSERT_SVH
`define PAGE_FRAMEBUFFER_PIXEL_LINE_DRAW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFLD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pfld_pkg.sv
// Shared types, codes and helpers for the page frame store line draw block.
// No dependencies; used by the top level of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfld_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int COORD_W = 14;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  localparam logic [2:0] REQ_PIXEL = 3'd0;
  localparam logic [2:0] REQ_HRUN  = 3'd1;
  localparam logic [2:0] REQ_VRUN  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] INK_BLACK  = 2'd0;
  localparam logic [1:0] INK_WHITE  = 2'd1;
  localparam logic [1:0] INK_INVERT = 2'd2;
  localparam logic [1:0] INK_NONE   = 2'd3;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0]        run_length;
    logic [1:0]         ink;
    logic [8:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              nothing_drawn;
  } out_item_t;

  // Apply one ink to the bits of a store byte selected by a mask.
  function automatic logic [BYTE_W-1:0] apply_ink(input logic [BYTE_W-1:0] data,
                                                   input logic [BYTE_W-1:0] mask,
                                                   input logic [1:0] ink);
    logic [BYTE_W-1:0] res;
    case (ink)
      INK_BLACK:  res = data & ~mask;
      INK_WHITE:  res = data | mask;
      INK_INVERT: res = data ^ mask;
      default:    res = data;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pfld_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/page_framebuffer_pixel_line_draw.sv
// Top level of the monochrome page frame store with pixel and run drawing.
// Depends on pfld_pkg, pfld_ram and the shared assertion macro header.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. It sets,
//   clears or toggles one pixel, draws a horizontal or vertical run, clears
//   the store, or reads back one store byte. Every item gives exactly one
//   result on out_item, shown for one cycle with out_valid high; the
//   receiver cannot stall, so the result is taken in that cycle. The
//   rotation register turns logical coordinates by quarter turns; the user
//   is to write it through cfg_we and cfg_wdata only while the block is
//   idle, which the block itself does not enforce.
// Steps from the accepting edge to the edge that raises out_valid: read
//   byte: S_RDBYTE; unused request codes: the result shows in the cycle
//   right after the accepting edge and busy stays low; pixel or run that
//   is clipped away or uses the no-effect ink: S_ROT, S_CLIP; pixel or run:
//   S_ROT, S_CLIP, S_INIT, then S_RD, S_WR per store byte touched (one per
//   column of a horizontal run, one per page of a vertical run), each a
//   read-modify-write through the one RAM port pair; clear store: S_CLEAR,
//   one byte a cycle. busy falls in the same cycle as out_valid rises.
// Reset: rotation returns to zero and a clearing pass writes zero to all
//   PANEL_WIDTH*ceil(PANEL_HEIGHT/8) store bytes (512 by default), with
//   busy high and no result; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "page_framebuffer_pixel_line_draw_assert.svh"

module page_framebuffer_pixel_line_draw #(
  parameter int PANEL_WIDTH  = pfld_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pfld_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire pfld_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output pfld_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_wdata
);

  localparam int PAGES   = (PANEL_HEIGHT + 7) / 8;
  localparam int DEPTH   = PANEL_WIDTH * PAGES;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int DW      = $clog2(DIM_MAX + 1);
  localparam int CNT_MAX = (PANEL_WIDTH > PAGES) ? PANEL_WIDTH : PAGES;
  localparam int NW      = $clog2(CNT_MAX + 1);
  localparam int CW      = pfld_pkg::COORD_W;
  localparam int BW      = pfld_pkg::BYTE_W;

  localparam logic signed [CW-1:0] W_S   = CW'(PANEL_WIDTH);
  localparam logic signed [CW-1:0] H_S   = CW'(PANEL_HEIGHT);
  localparam logic signed [CW-1:0] WM1_S = CW'(PANEL_WIDTH - 1);
  localparam logic signed [CW-1:0] HM1_S = CW'(PANEL_HEIGHT - 1);
  localparam logic signed [CW-1:0] ONE_S = CW'(1);
  localparam logic [AW-1:0]        W_A   = AW'(PANEL_WIDTH);
  localparam logic [AW-1:0]        ONE_A = AW'(1);
  localparam logic [AW-1:0]        LAST_A = AW'(DEPTH - 1);
  localparam logic [NW-1:0]        ONE_N = NW'(1);
  localparam logic [DW-1:0]        ONE_D = DW'(1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ROT    = 8'b0000_0010,
    S_CLIP   = 8'b0000_0100,
    S_INIT   = 8'b0000_1000,
    S_RD     = 8'b0001_0000,
    S_WR     = 8'b0010_0000,
    S_RDBYTE = 8'b0100_0000,
    S_CLEAR  = 8'b1000_0000
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          rotation_r;

  // Payload state.
  pfld_pkg::in_item_t  item_r;
  pfld_pkg::out_item_t out_item_r, out_item_nxt;
  logic signed [CW-1:0] s_a_r, c_a_r, len_r;
  logic signed [CW-1:0] s_a_nxt, c_a_nxt, len_nxt;
  logic                pv_r, pv_nxt;
  logic [DW-1:0]       s_r, e_r, c_r;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic                first_r, first_nxt;
  logic                rd_ok_r;

  // Rotation stage.
  logic signed [CW-1:0] x_s, y_s, lm1, px, py;
  logic                 vert;
  logic [10:0]          len_eff;

  // Clip stage.
  logic signed [CW-1:0] e_s, lim, clim, sc, ec;
  logic                 cross_ok, hit;

  // Loop setup and byte update.
  logic [DW-1:0]        em1;
  logic [AW-1:0]        init_addr;
  logic [NW-1:0]        init_cnt;
  logic [2:0]           lo_bit, hi_bit;
  logic [BW-1:0]        vmask, hmask, mask;

  // RAM port.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [BW-1:0]        ram_wdata, ram_rdata;
  logic [AW-1:0]        rd_addr_in;
  logic                 rd_ok_in;
  logic                 accept;
  logic                 in_loop;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign in_loop   = (state_r == S_RD) || (state_r == S_WR);

  assign rd_addr_in = AW'(in_item.read_index);
  assign rd_ok_in   = (32'(in_item.read_index) < DEPTH);

  // Rotation into panel coordinates; a pixel is a horizontal run of one.
  always_comb begin
    vert    = (item_r.req_type == pfld_pkg::REQ_VRUN);
    len_eff = (item_r.req_type == pfld_pkg::REQ_PIXEL) ? 11'd1 : item_r.run_length;
    x_s     = CW'($signed(item_r.pos_x));
    y_s     = CW'($signed(item_r.pos_y));
    len_nxt = CW'($signed({1'b0, len_eff}));
    lm1     = len_nxt - ONE_S;
    case (rotation_r)
      pfld_pkg::ROT_0: begin
        px     = x_s;
        py     = y_s;
        pv_nxt = vert;
      end
      pfld_pkg::ROT_90: begin
        px     = WM1_S - y_s - (vert ? lm1 : '0);
        py     = x_s;
        pv_nxt = !vert;
      end
      pfld_pkg::ROT_180: begin
        px     = WM1_S - x_s - (vert ? '0 : lm1);
        py     = HM1_S - y_s - (vert ? lm1 : '0);
        pv_nxt = vert;
      end
      default: begin
        px     = y_s;
        py     = HM1_S - x_s - (vert ? '0 : lm1);
        pv_nxt = !vert;
      end
    endcase
    s_a_nxt = pv_nxt ? py : px;
    c_a_nxt = pv_nxt ? px : py;
  end

  // Clip the run to the panel along its axis and check the cross coordinate.
  always_comb begin
    e_s      = s_a_r + len_r;
    lim      = pv_r ? H_S : W_S;
    clim     = pv_r ? W_S : H_S;
    cross_ok = !c_a_r[CW-1] && (c_a_r < clim);
    sc       = s_a_r[CW-1] ? '0 : s_a_r;
    ec       = (e_s > lim) ? lim : e_s;
    hit      = cross_ok && (ec > sc);
  end

  // Start address, byte count and masks of the byte loop.
  always_comb begin
    em1 = e_r - ONE_D;
    if (!pv_r) begin
      init_addr = AW'(32'(c_r >> 3) * PANEL_WIDTH + 32'(s_r));
      init_cnt  = NW'(e_r - s_r);
    end else begin
      init_addr = AW'(32'(s_r >> 3) * PANEL_WIDTH + 32'(c_r));
      init_cnt  = NW'((em1 >> 3) - (s_r >> 3) + ONE_D);
    end
    hmask  = BW'(1) << c_r[2:0];
    lo_bit = first_r ? s_r[2:0] : 3'd0;
    hi_bit = (cnt_r == ONE_N) ? em1[2:0] : 3'd7;
    vmask  = (pfld_pkg::BYTE_ONES << lo_bit) & (pfld_pkg::BYTE_ONES >> (3'd7 - hi_bit));
    mask   = pv_r ? vmask : hmask;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    clr_reply_nxt = clr_reply_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;
    ram_raddr     = addr_r;
    case (state_r)
      S_IDLE: begin
        ram_raddr = rd_addr_in;
        if (accept) begin
          if (in_item.req_type == pfld_pkg::REQ_PIXEL ||
              in_item.req_type == pfld_pkg::REQ_HRUN ||
              in_item.req_type == pfld_pkg::REQ_VRUN) begin
            state_nxt = S_ROT;
          end else if (in_item.req_type == pfld_pkg::REQ_CLEAR) begin
            addr_nxt      = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else if (in_item.req_type == pfld_pkg::REQ_READ) begin
            state_nxt = S_RDBYTE;
          end else begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end
        end
      end
      S_ROT: begin
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        if (hit && item_r.ink != pfld_pkg::INK_NONE) begin
          state_nxt = S_INIT;
        end else begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.read_data     = '0;
          out_item_nxt.nothing_drawn = !hit;
          state_nxt                  = S_IDLE;
        end
      end
      S_INIT: begin
        addr_nxt  = init_addr;
        cnt_nxt   = init_cnt;
        first_nxt = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = pfld_pkg::apply_ink(ram_rdata, mask, item_r.ink);
        addr_nxt  = addr_r + (pv_r ? W_A : ONE_A);
        cnt_nxt   = cnt_r - ONE_N;
        first_nxt = 1'b0;
        if (cnt_r == ONE_N) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RDBYTE: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.read_data     = rd_ok_r ? ram_rdata : '0;
        out_item_nxt.nothing_drawn = 1'b0;
        state_nxt                  = S_IDLE;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_nxt  = addr_r + ONE_A;
        if (addr_r == LAST_A) begin
          // The pass after reset gives no result; a clear request does.
          out_valid_nxt = clr_reply_r;
          out_item_nxt  = '0;
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      rotation_r  <= pfld_pkg::ROT_0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rotation_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    cnt_r      <= cnt_nxt;
    first_r    <= first_nxt;
    if (accept) begin
      item_r  <= in_item;
      rd_ok_r <= rd_ok_in;
    end
    if (state_r == S_ROT) begin
      s_a_r <= s_a_nxt;
      c_a_r <= c_a_nxt;
      len_r <= len_nxt;
      pv_r  <= pv_nxt;
    end
    if (state_r == S_CLIP) begin
      s_r <= DW'(sc);
      e_r <= DW'(ec);
      c_r <= DW'(c_a_r);
    end
  end

  pfld_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `PFLD_ASSERT_SAME(a_idle_no_write, clk, rst_n, state_r == S_IDLE, !ram_we, "idle write")
  `PFLD_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy || out_valid, "item dropped")
  `PFLD_ASSERT_SAME(a_loop_count, clk, rst_n, in_loop, cnt_r != '0, "empty byte loop")
  `PFLD_ASSERT_SAME(a_result_source, clk, rst_n, out_valid, $past(busy || start), "stray result")

endmodule

`default_nettype wire
